// ===== sv/aes_ctr_pkg.sv =====
// Package for the AES-256 CTR cipher: payload structs, register indexes, S-box and helpers.
// No dependencies.
package aes_ctr_pkg;

  typedef struct packed {
    logic        start_message;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  byte_count;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_req_t;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_IV_HI  = 3'd4;
  localparam logic [2:0] REG_IV_LO  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXPAND, ST_LOAD, ST_ROUND, ST_OUT
  } state_e;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ===== sv/aes_ctr_round.sv =====
// One AES encryption round on a 128-bit state (byte 0 in the top bits).
// Depends on aes_ctr_pkg for the S-box and xtime.
module aes_ctr_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         last_i,
  output logic [127:0] state_o
);

  logic [7:0] s   [16];
  logic [7:0] t   [16];
  logic [7:0] m   [16];
  logic [127:0] mixed;

  // SubBytes with ShiftRows, then MixColumns unless final round
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127 - 8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[4*c + r] = aes_ctr_pkg::SBOX[s[4*((c + r) % 4) + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      m[4*c]     = t[4*c]   ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                   ^ aes_ctr_pkg::xtime(t[4*c]   ^ t[4*c+1]);
      m[4*c + 1] = t[4*c+1] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                   ^ aes_ctr_pkg::xtime(t[4*c+1] ^ t[4*c+2]);
      m[4*c + 2] = t[4*c+2] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                   ^ aes_ctr_pkg::xtime(t[4*c+2] ^ t[4*c+3]);
      m[4*c + 3] = t[4*c+3] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3])
                   ^ aes_ctr_pkg::xtime(t[4*c+3] ^ t[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      mixed[127 - 8*i -: 8] = last_i ? t[i] : m[i];
    end
  end

  assign state_o = mixed ^ rkey_i;

endmodule

// ===== sv/aes256_ctr_stream_cipher.sv =====
// AES-256 CTR top level: register file, key expansion, round-key memory, round sequencer.
// Depends on aes_ctr_pkg and aes_ctr_round.
// A request passes the load state (initial key add), 14 rounds and the output state before its result is registered.
// A start request first runs key expansion, one 32-bit word per cycle, into a 15-row
// round-key memory (one 128-bit row written for every four new words).
// A new block is accepted only in idle, so each block finishes before the next; all rounds share the single round unit.
// Reset clears control, config and counter; round-key memory is not cleared.
module aes256_ctr_stream_cipher #(
  parameter int ROUND_COUNT = 14
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  aes_ctr_pkg::in_req_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output aes_ctr_pkg::out_req_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [63:0]           cfg_data_i
);

  localparam int NRK   = ROUND_COUNT + 1;     // 128-bit round keys
  localparam int NW32  = 4 * NRK;             // 32-bit expanded words
  localparam int RW    = $clog2(NRK);
  localparam int WW    = $clog2(NW32 + 1);

  // configuration registers
  logic [63:0] key_q [4];
  logic [63:0] iv_hi_q, iv_lo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) key_q[i] <= '0;
      iv_hi_q <= '0;
      iv_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        aes_ctr_pkg::REG_KEY0:  key_q[0] <= cfg_data_i;
        aes_ctr_pkg::REG_KEY1:  key_q[1] <= cfg_data_i;
        aes_ctr_pkg::REG_KEY2:  key_q[2] <= cfg_data_i;
        aes_ctr_pkg::REG_KEY3:  key_q[3] <= cfg_data_i;
        aes_ctr_pkg::REG_IV_HI: iv_hi_q  <= cfg_data_i;
        aes_ctr_pkg::REG_IV_LO: iv_lo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  aes_ctr_pkg::state_e state_q, state_d;
  aes_ctr_pkg::in_req_t req_q;
  logic [127:0] ctr_q, ctr_d;
  logic [127:0] st_q, st_d;
  logic [RW-1:0] rnd_q, rnd_d;
  logic [WW-1:0] wi_q, wi_d;
  logic [7:0]   rc_q, rc_d;
  logic [255:0] win_q, win_d;      // sliding window of last 8 key words
  logic         out_v_q, out_v_d;
  aes_ctr_pkg::out_req_t out_q, out_d;

  // round-key memory, 128-bit rows, registered read
  logic [127:0] rk_mem [NRK];
  logic [127:0] rk_rd_q;
  logic [RW-1:0] rd_addr;
  logic          wr_en;
  logic [RW-1:0] wr_addr;
  logic [127:0]  wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) rk_mem[wr_addr] <= wr_data;
    rk_rd_q <= rk_mem[rd_addr];
  end

  // key schedule: next 32-bit word from the window
  logic [31:0] prev_w, far_w, tw, new_w;
  always_comb begin
    prev_w = win_q[31:0];
    far_w  = win_q[255:224];
    if (wi_q[2:0] == 3'd0)
      tw = aes_ctr_pkg::sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_q, 24'h0};
    else if (wi_q[2:0] == 3'd4)
      tw = aes_ctr_pkg::sub_word(prev_w);
    else
      tw = prev_w;
    new_w = far_w ^ tw;
  end

  logic [127:0] rnd_out;
  aes_ctr_round u_round (
    .state_i (st_q),
    .rkey_i  (rk_rd_q),
    .last_i  (rnd_q == RW'(ROUND_COUNT)),
    .state_o (rnd_out)
  );

  logic accept;
  assign in_stall_o = (state_q != aes_ctr_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      aes_ctr_pkg::ST_IDLE:
        if (accept) state_d = in_data_i.start_message ? aes_ctr_pkg::ST_EXPAND
                                                      : aes_ctr_pkg::ST_LOAD;
      aes_ctr_pkg::ST_EXPAND:
        if (wi_q == WW'(NW32 - 1)) state_d = aes_ctr_pkg::ST_LOAD;
      aes_ctr_pkg::ST_LOAD:  state_d = aes_ctr_pkg::ST_ROUND;
      aes_ctr_pkg::ST_ROUND:
        if (rnd_q == RW'(ROUND_COUNT)) state_d = aes_ctr_pkg::ST_OUT;
      aes_ctr_pkg::ST_OUT:
        if (!out_v_q || !out_stall_i) state_d = aes_ctr_pkg::ST_IDLE;
      default: state_d = aes_ctr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  logic [127:0] mask;
  always_comb begin
    ctr_d   = ctr_q;
    st_d    = st_q;
    rnd_d   = rnd_q;
    wi_d    = wi_q;
    rc_d    = rc_q;
    win_d   = win_q;
    out_v_d = out_v_q && out_stall_i;
    out_d   = out_q;
    wr_en   = 1'b0;
    wr_addr = RW'(wi_q[WW-1:2]);
    wr_data = {win_q[95:0], new_w};
    rd_addr = rnd_q;
    for (int i = 0; i < 16; i++)
      mask[127 - 8*i -: 8] = (5'(i) < req_q.byte_count) ? 8'hff : 8'h00;
    unique case (state_q)
      aes_ctr_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (accept && in_data_i.start_message) begin
          ctr_d = {iv_hi_q, iv_lo_q};
          win_d = {key_q[0], key_q[1], key_q[2], key_q[3]};
          wi_d  = WW'(8);
          rc_d  = 8'h01;
        end
      end
      aes_ctr_pkg::ST_EXPAND: begin
        // first two rows are the raw key; write them on the first two steps
        if (wi_q == WW'(8)) begin
          wr_en = 1'b1; wr_addr = '0; wr_data = win_q[255:128];
        end else if (wi_q == WW'(9)) begin
          wr_en = 1'b1; wr_addr = RW'(1); wr_data = win_q[159:32];
        end
        if (wi_q[1:0] == 2'd3 && wi_q > WW'(10)) wr_en = 1'b1;
        win_d = {win_q[223:0], new_w};
        if (wi_q[2:0] == 3'd0) rc_d = aes_ctr_pkg::xtime(rc_q);
        wi_d  = wi_q + WW'(1);
        rd_addr = '0;
      end
      aes_ctr_pkg::ST_LOAD: begin
        st_d  = ctr_q ^ rk_rd_q;
        rnd_d = RW'(1);
        rd_addr = RW'(1);
      end
      aes_ctr_pkg::ST_ROUND: begin
        st_d  = rnd_out;
        rnd_d = rnd_q + RW'(1);
        rd_addr = (rnd_q == RW'(ROUND_COUNT)) ? '0 : rnd_q + RW'(1);
        if (rnd_q == RW'(ROUND_COUNT)) begin
          ctr_d = ctr_q + 128'd1;
        end
      end
      aes_ctr_pkg::ST_OUT: begin
        if (!out_v_q || !out_stall_i) begin
          out_v_d = 1'b1;
          {out_d.result_high, out_d.result_low} = {req_q.data_high, req_q.data_low}
                                                  ^ (st_q & mask);
        end
      end
      default: ;
    endcase
  end

  logic [4:0] bc_sat;
  assign bc_sat = (in_data_i.byte_count > 5'd16) ? 5'd16 : in_data_i.byte_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aes_ctr_pkg::ST_IDLE;
      ctr_q   <= '0;
      out_v_q <= 1'b0;
      rnd_q   <= '0;
      wi_q    <= '0;
      rc_q    <= 8'h01;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      out_v_q <= out_v_d;
      rnd_q   <= rnd_d;
      wi_q    <= wi_d;
      rc_q    <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    win_q <= win_d;
    out_q <= out_d;
    if (accept) begin
      req_q <= {in_data_i.start_message, in_data_i.data_high, in_data_i.data_low, bc_sat};
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/aes256_ctr_stream_cipher_chk.sv =====
// Port-level checker for the AES-256 CTR cipher, with its bind.
// Depends on aes_ctr_pkg for the payload types.
module aes256_ctr_stream_cipher_chk (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input aes_ctr_pkg::out_req_t out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // an accepted request blocks the input for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after request");

  // no result appears right after a request
  a_no_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !(out_valid_o && out_stall_i) |=> !$rose(out_valid_o))
    else $error("result too early");

endmodule

bind aes256_ctr_stream_cipher aes256_ctr_stream_cipher_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
